// ----- src/ifmt_pkg.sv -----
package ifmt_pkg;

    localparam int VALUE_BITS_DEF  = 64;
    localparam int DIGIT_SLOTS_DEF = 64;
    localparam int MAX_RUN_DEF     = 64;

    // Character positions within one run never exceed 67, so seven bits hold them.
    localparam int POS_W = 7;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    typedef struct packed {
        logic [63:0] value;
        logic        treat_signed;
        logic [1:0]  radix_select;
        logic        upper_case;
        logic        alt_form;
        logic        left_justify;
        logic        force_plus;
        logic        space_sign;
        logic        zero_pad;
        logic [5:0]  field_width;
        logic [5:0]  precision;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
        logic       truncated;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_DIGITS,
        ST_CALC,
        ST_PREP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic digit;
        logic calc;
        logic prep;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_is_dec;
        logic dabble_done;
        logic digits_done;
        logic out_free;
        logic emit_last;
    } t_status;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UP_A : CH_LOW_A;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ----- src/ifmt_ram.sv -----
module ifmt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ifmt_ctrl.sv -----
module ifmt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ifmt_pkg::t_status i_status,
    output ifmt_pkg::t_cmd    o_cmd
);
    import ifmt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_is_dec ? ST_DABBLE : ST_DIGITS;
                end
            end
            ST_DABBLE: begin
                o_cmd.dabble = 1'b1;
                if (i_status.dabble_done) begin
                    n_state = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                o_cmd.digit = 1'b1;
                if (i_status.digits_done) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/ifmt_dp.sv -----
module ifmt_dp #(
    parameter int VALUE_BITS  = ifmt_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_SLOTS = ifmt_pkg::DIGIT_SLOTS_DEF,
    parameter int MAX_RUN     = ifmt_pkg::MAX_RUN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ifmt_pkg::t_in_item  i_in_item,
    input  ifmt_pkg::t_cmd      i_cmd,
    output ifmt_pkg::t_status   o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output ifmt_pkg::t_out_item o_out_item
);
    import ifmt_pkg::*;

    localparam int BCD_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
    localparam int RW         = 4 * BCD_DIGITS;
    localparam int BCNT_W     = $clog2(VALUE_BITS);
    localparam int DCW        = $clog2(DIGIT_SLOTS + 1);
    localparam int AW         = $clog2(DIGIT_SLOTS);

    // Request fields kept for the whole item.
    logic [1:0]        r_radix;
    logic              r_upper_hex;
    logic              r_left;
    logic              r_zpad;
    logic [5:0]        r_width;
    logic [5:0]        r_prec;
    logic [7:0]        r_pre [4];
    logic [1:0]        r_pre_n;

    logic [VALUE_BITS-1:0] r_src;
    logic [RW-1:0]         r_rem;
    logic [BCNT_W-1:0]     r_bcnt;
    logic [DCW-1:0]        r_dc;
    logic                  r_lost;

    logic [POS_W-1:0] r_bpre;
    logic [POS_W-1:0] r_brp;
    logic [POS_W-1:0] r_bz;
    logic [POS_W-1:0] r_bd;
    logic [POS_W-1:0] r_total;
    logic             r_trunc;
    logic [POS_W-1:0] r_p;

    logic      r_ov;
    t_out_item r_out;

    // Prefix and sign characters of the item being offered.
    logic [VALUE_BITS-1:0] in_v;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [7:0]            pre [4];
    logic [1:0]            pre_n;

    always_comb begin
        in_v   = i_in_item.value[VALUE_BITS-1:0];
        in_neg = i_in_item.treat_signed & in_v[VALUE_BITS-1];
        in_mag = in_neg ? (~in_v + 1'b1) : in_v;
        pre    = '{default: CH_SPACE};
        pre_n  = 2'd0;
        if (i_in_item.alt_form) begin
            case (i_in_item.radix_select)
                RADIX_BIN: begin
                    pre[0] = CH_ZERO;
                    pre[1] = CH_LOW_B;
                    pre_n  = 2'd2;
                end
                RADIX_OCT: begin
                    pre[0] = CH_ZERO;
                    pre_n  = 2'd1;
                end
                RADIX_HEX: begin
                    pre[0] = CH_ZERO;
                    pre[1] = CH_LOW_X;
                    pre_n  = 2'd2;
                end
                default: begin
                end
            endcase
        end
        if (in_neg) begin
            pre[pre_n] = CH_MINUS;
            pre_n      = pre_n + 2'd1;
        end else if (i_in_item.treat_signed && i_in_item.force_plus) begin
            pre[pre_n] = CH_PLUS;
            pre_n      = pre_n + 2'd1;
        end else if (i_in_item.treat_signed && i_in_item.space_sign) begin
            pre[pre_n] = CH_SPACE;
            pre_n      = pre_n + 2'd1;
        end
    end

    // Double-dabble step: correct every BCD digit, then shift in one binary bit.
    logic [RW-1:0] adj;

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            adj[4*k +: 4] = (r_rem[4*k +: 4] >= 4'd5) ? r_rem[4*k +: 4] + 4'd3
                                                      : r_rem[4*k +: 4];
        end
    end

    // Digit extraction from the low end of the remaining value.
    logic [RW-1:0] n_rem;
    logic [3:0]    dig;

    always_comb begin
        case (r_radix)
            RADIX_BIN: begin
                n_rem = r_rem >> 1;
                dig   = {3'd0, r_rem[0]};
            end
            RADIX_OCT: begin
                n_rem = r_rem >> 3;
                dig   = {1'b0, r_rem[2:0]};
            end
            default: begin
                n_rem = r_rem >> 4;
                dig   = r_rem[3:0];
            end
        endcase
    end

    // Run layout: prefix and sign, right padding, precision zeros, digits, left padding.
    logic [POS_W-1:0] c_len;
    logic [POS_W-1:0] c_zeros;
    logic [POS_W-1:0] c_len2;
    logic [POS_W-1:0] c_pad;
    logic [POS_W-1:0] c_n;
    logic [POS_W-1:0] c_rpad;
    logic [POS_W-1:0] c_dc;
    logic [POS_W-1:0] c_prec;
    logic [POS_W-1:0] c_width;

    always_comb begin
        c_dc    = POS_W'(r_dc);
        c_prec  = POS_W'(r_prec);
        c_width = POS_W'(r_width);
        c_len   = POS_W'(r_pre_n) + c_dc;
        c_zeros = (c_prec > c_len) ? c_prec - c_len : '0;
        c_len2  = c_len + c_zeros;
        c_pad   = (c_width > c_len2) ? c_width - c_len2 : '0;
        c_n     = c_len2 + c_pad;
        c_rpad  = r_left ? '0 : c_pad;
    end

    // The digit store is read one position ahead so its registered data lines up with r_p.
    logic [POS_W-1:0] n_p;
    logic [POS_W-1:0] rd_off;
    logic [3:0]       rdata;

    always_comb begin
        if (i_cmd.prep) begin
            n_p = '0;
        end else if (i_cmd.emit) begin
            n_p = r_p + 1'b1;
        end else begin
            n_p = r_p;
        end
        rd_off = r_bd - 1'b1 - n_p;
    end

    ifmt_ram #(
        .WIDTH(4),
        .DEPTH(DIGIT_SLOTS)
    ) u_digit_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.digit),
        .i_waddr(r_dc[AW-1:0]),
        .i_wdata(dig),
        .i_raddr(rd_off[AW-1:0]),
        .o_rdata(rdata)
    );

    logic [7:0] cur_char;
    logic       cur_last;

    always_comb begin
        if (r_p < r_bpre) begin
            cur_char = r_pre[r_p[1:0]];
        end else if (r_p < r_brp) begin
            cur_char = r_zpad ? CH_ZERO : CH_SPACE;
        end else if (r_p < r_bz) begin
            cur_char = CH_ZERO;
        end else if (r_p < r_bd) begin
            cur_char = digit_char(rdata, r_upper_hex);
        end else begin
            cur_char = CH_SPACE;
        end
        cur_last = (r_p + 1'b1) == r_total;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix     <= i_in_item.radix_select;
            r_upper_hex <= i_in_item.upper_case && (i_in_item.radix_select == RADIX_HEX);
            r_left      <= i_in_item.left_justify;
            r_zpad      <= i_in_item.zero_pad;
            r_width     <= i_in_item.field_width;
            r_prec      <= i_in_item.precision;
            r_pre       <= pre;
            r_pre_n     <= pre_n;
            r_src       <= in_mag;
            r_rem       <= (i_in_item.radix_select == RADIX_DEC) ? '0 : RW'(in_mag);
            r_bcnt      <= '0;
            r_dc        <= '0;
        end
        if (i_cmd.dabble) begin
            r_rem  <= {adj[RW-2:0], r_src[VALUE_BITS-1]};
            r_src  <= r_src << 1;
            r_bcnt <= r_bcnt + 1'b1;
        end
        if (i_cmd.digit) begin
            r_rem  <= n_rem;
            r_dc   <= r_dc + 1'b1;
            r_lost <= n_rem != '0;
        end
        if (i_cmd.calc) begin
            r_bpre  <= POS_W'(r_pre_n);
            r_brp   <= POS_W'(r_pre_n) + c_rpad;
            r_bz    <= POS_W'(r_pre_n) + c_rpad + c_zeros;
            r_bd    <= POS_W'(r_pre_n) + c_rpad + c_zeros + c_dc;
            r_total <= (c_n > POS_W'(MAX_RUN)) ? POS_W'(MAX_RUN) : c_n;
            r_trunc <= (c_n > POS_W'(MAX_RUN)) || r_lost;
        end
        r_p <= n_p;
        if (i_cmd.emit) begin
            r_out.character <= cur_char;
            r_out.last_char <= cur_last;
            r_out.truncated <= cur_last && r_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_status.in_is_dec   = i_in_item.radix_select == RADIX_DEC;
    assign o_status.dabble_done = r_bcnt == BCNT_W'(VALUE_BITS - 1);
    assign o_status.digits_done = (n_rem == '0) || (r_dc == DCW'(DIGIT_SLOTS - 1));
    assign o_status.out_free    = !r_ov || i_out_ready;
    assign o_status.emit_last   = cur_last;

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

// ----- src/integer_to_ascii_formatter.sv -----
// Integer to ASCII formatter.
// The input channel (i_in_valid, o_in_ready, i_in_item) takes one value with its
// conversion request. The output channel (o_out_valid, i_out_ready, o_out_item)
// returns the text one character per item, the last one marked by last_char, and
// truncated set on it when the run was cut at MAX_RUN characters or digits were lost.
// Decimal values first pass through a binary to BCD converter, one bit per cycle.
// Every radix then moves one digit per cycle into the digit store, a layout step
// lays out the run and a prepare step primes the store read, after which characters
// leave one per cycle while the receiver accepts them.
// A new item is taken only after the previous one has issued its last character,
// while that character may still wait in the output register.
// When the receiver stalls, the output register holds its item and the run pauses.
// Reset idles the controller and empties the output register; no clearing pass.
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS  = ifmt_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_SLOTS = ifmt_pkg::DIGIT_SLOTS_DEF,
    parameter int MAX_RUN     = ifmt_pkg::MAX_RUN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ifmt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ifmt_pkg::t_out_item o_out_item
);
    import ifmt_pkg::*;

    t_cmd    cmd;
    t_status status;

    ifmt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    ifmt_dp #(
        .VALUE_BITS (VALUE_BITS),
        .DIGIT_SLOTS(DIGIT_SLOTS),
        .MAX_RUN    (MAX_RUN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );

    a_trunc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.truncated || o_out_item.last_char))
        else $error("truncated flag on a character that is not the last");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after an item was accepted");

    a_no_char_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("character emitted directly from the idle state");

    a_emit_not_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !o_in_ready)
        else $error("character issued while the input side is open");

endmodule
